/* design/assert_macros.svh */
// Assertion macros shared by the interlock modules.
// Each macro samples on the rising edge of aclk and is disabled while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge out of reset.
`define VSI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge out of reset.
`define VSI_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`else

`define VSI_ASSERT(lbl, prop, msg)
`define VSI_NEVER(lbl, cond, msg)

`endif

`endif

/* design/vsi_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package vsi_pkg;

    // Opcodes carried on s_tuser
    localparam logic [1:0] OP_DRIVE   = 2'd0;
    localparam logic [1:0] OP_SAMPLE  = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;
    localparam logic [1:0] OP_PUBLISH = 2'd3;

    // Result kinds carried on m_tuser
    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_EVENT   = 1'b1;

    // Severity codes
    localparam logic [1:0] SEV_INFO    = 2'd0;
    localparam logic [1:0] SEV_WARNING = 2'd1;
    localparam logic [1:0] SEV_STOP    = 2'd2;

    // Rule codes
    localparam logic [1:0] RULE_NONE     = 2'd0;
    localparam logic [1:0] RULE_CMD_OLD  = 2'd1;
    localparam logic [1:0] RULE_SCAN_OLD = 2'd2;
    localparam logic [1:0] RULE_FRONT    = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FWD    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REV    = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CMD_LIMIT  = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_LIMIT = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_RANGE = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_ANGLE = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_REQ   = 4'd7;

    // Configuration reset values
    localparam logic [14:0] RST_MAX_FWD    = 15'd400;
    localparam logic [14:0] RST_MAX_REV    = 15'd200;
    localparam logic [14:0] RST_MAX_TURN   = 15'd800;
    localparam logic [15:0] RST_CMD_LIMIT  = 16'd300;
    localparam logic [15:0] RST_SCAN_LIMIT = 16'd500;
    localparam logic [15:0] RST_STOP_RANGE = 16'd450;
    localparam logic [11:0] RST_HALF_ANGLE = 12'd520;
    localparam logic        RST_SCAN_REQ   = 1'b0;

    // Nearest-range value meaning no return, above any 16-bit range
    localparam logic [16:0] NO_RETURN = 17'h10000;
    localparam logic [15:0] AGE_MAX   = 16'hFFFF;

    // Port widths
    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 40;
    localparam int unsigned RES_SLOTS = 3;

    typedef struct packed {
        logic [14:0] max_fwd;
        logic [14:0] max_rev;
        logic [14:0] max_turn;
        logic [15:0] cmd_limit;
        logic [15:0] scan_limit;
        logic [15:0] stop_range;
        logic [11:0] half_angle;
        logic        scan_req;
    } cfg_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] safe_forward;
        logic signed [15:0] safe_turn;
        logic [1:0]         severity;
        logic [1:0]         rule;
        logic               event_active;
        logic               last;
    } result_t;

    // Results of one publish request, handed from the core to the result buffer
    typedef struct packed {
        logic                 valid;
        logic [1:0]           cnt;
        result_t [RES_SLOTS-1:0] slot;
    } res_load_t;

endpackage

`default_nettype wire

/* design/vsi_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module vsi_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data,
    output vsi_pkg::cfg_t                      cfg
);
    import vsi_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a configuration write
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    // Decode the register index; unknown indexes leave everything as it is
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_MAX_FWD:    cfg_next.max_fwd    = cfg_data[14:0];
                REG_MAX_REV:    cfg_next.max_rev    = cfg_data[14:0];
                REG_MAX_TURN:   cfg_next.max_turn   = cfg_data[14:0];
                REG_CMD_LIMIT:  cfg_next.cmd_limit  = cfg_data;
                REG_SCAN_LIMIT: cfg_next.scan_limit = cfg_data;
                REG_STOP_RANGE: cfg_next.stop_range = cfg_data;
                REG_HALF_ANGLE: cfg_next.half_angle = cfg_data[11:0];
                REG_SCAN_REQ:   cfg_next.scan_req   = cfg_data[0];
                default:        cfg_next            = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.max_fwd    <= RST_MAX_FWD;
            cfg_reg.max_rev    <= RST_MAX_REV;
            cfg_reg.max_turn   <= RST_MAX_TURN;
            cfg_reg.cmd_limit  <= RST_CMD_LIMIT;
            cfg_reg.scan_limit <= RST_SCAN_LIMIT;
            cfg_reg.stop_range <= RST_STOP_RANGE;
            cfg_reg.half_angle <= RST_HALF_ANGLE;
            cfg_reg.scan_req   <= RST_SCAN_REQ;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* design/vsi_core.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vsi_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire vsi_pkg::cfg_t                 cfg,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vsi_pkg::S_TDATA_W-1:0] s_tdata,  // fwd, turn, angle, range, finite, floor, ceiling
    input  wire logic [1:0]                    s_tuser,  // opcode
    input  wire logic                          s_tlast,  // scan_end
    input  wire logic                          buf_free,
    output vsi_pkg::res_load_t                 load
);
    import vsi_pkg::*;

    // Input register
    logic                 in_valid_reg;
    logic [S_TDATA_W-1:0] in_data_reg;
    logic [1:0]           in_op_reg;
    logic                 in_last_reg;

    // Block state
    logic signed [15:0] held_fwd_reg,  held_fwd_next;
    logic signed [15:0] held_turn_reg, held_turn_next;
    logic               cmd_seen_reg,  cmd_seen_next;
    logic [15:0]        cmd_age_reg,   cmd_age_next;
    logic               scan_seen_reg, scan_seen_next;
    logic [15:0]        scan_age_reg,  scan_age_next;
    logic [16:0]        near_com_reg,  near_com_next;
    logic [16:0]        near_work_reg, near_work_next;
    logic               scan_open_reg, scan_open_next;
    logic [1:0]         cur_rule_reg,  cur_rule_next;
    logic [1:0]         cur_sev_reg,   cur_sev_next;

    // Unpacked fields of the held item
    logic signed [15:0] f_fwd;
    logic signed [15:0] f_turn;
    logic [12:0]        f_angle;
    logic [15:0]        f_range;
    logic               f_finite;
    logic [15:0]        f_floor;
    logic [15:0]        f_ceil;

    logic        advance;
    logic        is_pub;
    logic [12:0] angle_mag;
    logic [16:0] work_base;
    logic        sample_hit;
    logic [16:0] work_new;

    logic               cmd_fresh;
    logic               scan_current;
    logic signed [16:0] fwd_ext, turn_ext, fwd_lo, fwd_hi, turn_lo, turn_hi;
    logic signed [15:0] fwd_clamp, turn_clamp;
    logic [1:0]         new_rule, new_sev;
    logic               stopped;
    logic               changed, send_clear, send_raise;
    result_t            ev_clear, ev_raise, cmd_res;

    assign f_fwd    = in_data_reg[15:0];
    assign f_turn   = in_data_reg[31:16];
    assign f_angle  = in_data_reg[44:32];
    assign f_range  = in_data_reg[60:45];
    assign f_finite = in_data_reg[61];
    assign f_floor  = in_data_reg[77:62];
    assign f_ceil   = in_data_reg[93:78];

    // Only a publish needs room in the result buffer
    assign is_pub   = (in_op_reg == OP_PUBLISH);
    assign advance  = in_valid_reg && (!is_pub || buf_free);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_op_reg   <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    // Scan sample: front sector and sensor bounds check, running minimum
    always_comb begin
        angle_mag  = f_angle[12] ? (~f_angle + 13'd1) : f_angle;
        work_base  = scan_open_reg ? near_work_reg : NO_RETURN;
        sample_hit = f_finite && (angle_mag <= {1'b0, cfg.half_angle})
                     && (f_range >= f_floor) && (f_range <= f_ceil)
                     && ({1'b0, f_range} < work_base);
        work_new   = sample_hit ? {1'b0, f_range} : work_base;
    end

    // Publish: freshness, clamps and the front obstacle rule
    always_comb begin
        cmd_fresh    = cmd_seen_reg && (cmd_age_reg <= cfg.cmd_limit);
        scan_current = scan_seen_reg && (scan_age_reg <= cfg.scan_limit);

        fwd_ext  = {held_fwd_reg[15], held_fwd_reg};
        turn_ext = {held_turn_reg[15], held_turn_reg};
        fwd_hi   = $signed({2'b00, cfg.max_fwd});
        fwd_lo   = -$signed({2'b00, cfg.max_rev});
        turn_hi  = $signed({2'b00, cfg.max_turn});
        turn_lo  = -$signed({2'b00, cfg.max_turn});

        if (fwd_ext < fwd_lo)      fwd_clamp = fwd_lo[15:0];
        else if (fwd_ext > fwd_hi) fwd_clamp = fwd_hi[15:0];
        else                       fwd_clamp = held_fwd_reg;

        if (turn_ext < turn_lo)      turn_clamp = turn_lo[15:0];
        else if (turn_ext > turn_hi) turn_clamp = turn_hi[15:0];
        else                         turn_clamp = held_turn_reg;

        stopped = 1'b1;
        if (!cmd_fresh) begin
            new_rule = RULE_CMD_OLD;
            new_sev  = SEV_WARNING;
        end else if (cfg.scan_req && !scan_current) begin
            new_rule = RULE_SCAN_OLD;
            new_sev  = SEV_STOP;
        end else if ((fwd_clamp > 16'sd0) && scan_current
                     && (near_com_reg < {1'b0, cfg.stop_range})) begin
            new_rule = RULE_FRONT;
            new_sev  = SEV_STOP;
        end else begin
            new_rule = RULE_NONE;
            new_sev  = SEV_INFO;
            stopped  = 1'b0;
        end

        changed    = (new_rule != cur_rule_reg) || (new_sev != cur_sev_reg);
        send_clear = changed && (cur_rule_reg != RULE_NONE);
        send_raise = changed && (new_rule != RULE_NONE);

        ev_clear.kind         = KIND_EVENT;
        ev_clear.safe_forward = 16'sd0;
        ev_clear.safe_turn    = 16'sd0;
        ev_clear.severity     = cur_sev_reg;
        ev_clear.rule         = cur_rule_reg;
        ev_clear.event_active = 1'b0;
        ev_clear.last         = 1'b0;

        ev_raise              = ev_clear;
        ev_raise.severity     = new_sev;
        ev_raise.rule         = new_rule;
        ev_raise.event_active = 1'b1;

        cmd_res.kind         = KIND_COMMAND;
        cmd_res.safe_forward = stopped ? 16'sd0 : fwd_clamp;
        cmd_res.safe_turn    = stopped ? 16'sd0 : turn_clamp;
        cmd_res.severity     = SEV_INFO;
        cmd_res.rule         = RULE_NONE;
        cmd_res.event_active = 1'b0;
        cmd_res.last         = 1'b1;
    end

    // Order the results: cleared event, raised event, then the command
    always_comb begin
        load.valid = advance && is_pub;
        load.slot  = {RES_SLOTS{cmd_res}};
        case ({send_clear, send_raise})
            2'b11: begin
                load.cnt     = 2'd3;
                load.slot[0] = ev_clear;
                load.slot[1] = ev_raise;
                load.slot[2] = cmd_res;
            end
            2'b10: begin
                load.cnt     = 2'd2;
                load.slot[0] = ev_clear;
                load.slot[1] = cmd_res;
            end
            2'b01: begin
                load.cnt     = 2'd2;
                load.slot[0] = ev_raise;
                load.slot[1] = cmd_res;
            end
            default: begin
                load.cnt     = 2'd1;
                load.slot[0] = cmd_res;
            end
        endcase
    end

    // Next state for the item leaving the input register
    always_comb begin
        held_fwd_next  = held_fwd_reg;
        held_turn_next = held_turn_reg;
        cmd_seen_next  = cmd_seen_reg;
        cmd_age_next   = cmd_age_reg;
        scan_seen_next = scan_seen_reg;
        scan_age_next  = scan_age_reg;
        near_com_next  = near_com_reg;
        near_work_next = near_work_reg;
        scan_open_next = scan_open_reg;
        cur_rule_next  = cur_rule_reg;
        cur_sev_next   = cur_sev_reg;
        if (advance) begin
            case (in_op_reg)
                OP_DRIVE: begin
                    held_fwd_next  = f_fwd;
                    held_turn_next = f_turn;
                    cmd_seen_next  = 1'b1;
                    cmd_age_next   = 16'd0;
                end
                OP_SAMPLE: begin
                    if (in_last_reg) begin
                        near_com_next  = work_new;
                        near_work_next = NO_RETURN;
                        scan_open_next = 1'b0;
                        scan_seen_next = 1'b1;
                        scan_age_next  = 16'd0;
                    end else begin
                        near_work_next = work_new;
                        scan_open_next = 1'b1;
                    end
                end
                OP_TICK: begin
                    if (cmd_age_reg != AGE_MAX)  cmd_age_next  = cmd_age_reg + 16'd1;
                    if (scan_age_reg != AGE_MAX) scan_age_next = scan_age_reg + 16'd1;
                end
                default: begin
                    cur_rule_next = new_rule;
                    cur_sev_next  = new_sev;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_fwd_reg  <= 16'sd0;
            held_turn_reg <= 16'sd0;
            cmd_seen_reg  <= 1'b0;
            cmd_age_reg   <= 16'd0;
            scan_seen_reg <= 1'b0;
            scan_age_reg  <= 16'd0;
            near_com_reg  <= NO_RETURN;
            near_work_reg <= NO_RETURN;
            scan_open_reg <= 1'b0;
            cur_rule_reg  <= RULE_NONE;
            cur_sev_reg   <= SEV_INFO;
        end else begin
            held_fwd_reg  <= held_fwd_next;
            held_turn_reg <= held_turn_next;
            cmd_seen_reg  <= cmd_seen_next;
            cmd_age_reg   <= cmd_age_next;
            scan_seen_reg <= scan_seen_next;
            scan_age_reg  <= scan_age_next;
            near_com_reg  <= near_com_next;
            near_work_reg <= near_work_next;
            scan_open_reg <= scan_open_next;
            cur_rule_reg  <= cur_rule_next;
            cur_sev_reg   <= cur_sev_next;
        end
    end

    // Working minimum is idle at the no-return value between scans
    `VSI_ASSERT(a_work_idle, !scan_open_reg |-> (near_work_reg == NO_RETURN), "working min not idle")
    // No rule means info severity; command staleness is only ever a warning
    `VSI_ASSERT(a_rule_sev, (cur_rule_reg == RULE_NONE) |-> (cur_sev_reg == SEV_INFO), "none rule with severity")
    `VSI_ASSERT(a_cmd_warn, (cur_rule_reg == RULE_CMD_OLD) |-> (cur_sev_reg == SEV_WARNING), "stale command severity")
    // A publish is never dropped while the result buffer is busy
    `VSI_NEVER(a_pub_drop, in_valid_reg && is_pub && !buf_free && advance, "publish advanced into busy buffer")

endmodule

`default_nettype wire

/* design/vsi_out.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module vsi_out (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire vsi_pkg::res_load_t            load,
    output logic                               buf_free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [vsi_pkg::M_TDATA_W-1:0]      m_tdata,  // safe_forward, safe_turn, severity, rule, event_active
    output logic                               m_tuser,  // kind
    output logic                               m_tlast   // last
);
    import vsi_pkg::*;

    logic                    buf_valid_reg;
    logic [1:0]              cnt_reg;
    logic [1:0]              idx_reg;
    result_t [RES_SLOTS-1:0] res_reg;
    result_t                 cur;
    logic                    take;
    logic                    at_end;

    assign cur      = res_reg[idx_reg];
    assign take     = buf_valid_reg && m_tready;
    assign at_end   = (idx_reg == (cnt_reg - 2'd1));
    assign buf_free = !buf_valid_reg || (take && at_end);

    assign m_tvalid = buf_valid_reg;
    assign m_tuser  = cur.kind;
    assign m_tlast  = cur.last;
    assign m_tdata  = {3'b000, cur.event_active, cur.rule, cur.severity,
                       cur.safe_turn, cur.safe_forward};

    // Load a new set of results, else step through the current one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            cnt_reg       <= 2'd0;
        end else if (load.valid) begin
            buf_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
            cnt_reg       <= load.cnt;
        end else if (take) begin
            if (at_end) begin
                buf_valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load.valid) begin
            res_reg <= load.slot;
        end
    end

    `VSI_ASSERT(a_cnt_ok, buf_valid_reg |-> ((cnt_reg != 2'd0) && (idx_reg < cnt_reg)), "bad result index")
    `VSI_ASSERT(a_ev_zero, (buf_valid_reg && (cur.kind == KIND_EVENT)) |-> ((cur.safe_forward == 16'sd0) && (cur.safe_turn == 16'sd0) && !cur.last), "event carries motion")
    `VSI_ASSERT(a_drain, (take && at_end && !load.valid) |=> !buf_valid_reg, "buffer not drained")

endmodule

`default_nettype wire

/* design/velocity_safety_interlock.sv */
`timescale 1ns / 1ps
`default_nettype none

// Velocity safety interlock.
// Input stream (s_*): one item per request; s_tuser is the opcode (drive command,
// scan sample, time tick, publish request), s_tlast marks the last sample of a scan.
// Result stream (m_*): m_tuser is the kind (0 command, 1 safety event), m_tlast is
// set on the command that closes each publish. Only publish requests give results:
// an optional cleared event, an optional raised event, then the safe command.
// Configuration (cfg_*): index and 16-bit data, always ready; write only while idle.
// An accepted item is held in the input register and evaluated there; a publish waits there
// until the result buffer is free, then its results are registered into the buffer.
// Throughput: one item per cycle while no publish waits for the busy result buffer.
// A publish holds the result buffer until its results (one to three) are all taken;
// drive, sample and tick items pass even while it drains.
// Reset clears all state: no command or scan seen, no rule active, registers at defaults.
// While m_tready is low the current result holds; a second publish waits in the input
// register, and s_tready drops only then.

module velocity_safety_interlock (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [vsi_pkg::S_TDATA_W-1:0] s_tdata,  // forward_speed, turn_rate,
                                                         // sample_angle, sample_range,
                                                         // sample_finite, range_floor,
                                                         // range_ceiling
    input  wire logic [1:0]                    s_tuser,  // opcode
    input  wire logic                          s_tlast,  // scan_end
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [vsi_pkg::M_TDATA_W-1:0]      m_tdata,  // safe_forward, safe_turn, severity,
                                                         // rule, event_active
    output logic                               m_tuser,  // kind
    output logic                               m_tlast,  // last
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vsi_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [15:0]                   cfg_data
);
    import vsi_pkg::*;

    cfg_t      cfg;
    res_load_t load;
    logic      buf_free;

    vsi_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    vsi_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .buf_free (buf_free),
        .load     (load)
    );

    vsi_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (load),
        .buf_free (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
